### rtl/ltpd_pkg.sv
`timescale 1ns / 1ps

package ltpd_pkg;

    localparam int HEADER_BYTES = 8;
    localparam int WORD_BYTES   = 4;
    localparam int COUNT_W      = $clog2(HEADER_BYTES);

    localparam logic [COUNT_W-1:0] LAST_HEADER_POS = COUNT_W'(HEADER_BYTES - 1);

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic [31:0] message_type;
        logic [31:0] message_length;
        logic        first_of_message;
        logic        last_of_message;
        logic        empty_message;
    } t_result;

endpackage

### rtl/ltpd_core.sv
`timescale 1ns / 1ps

module ltpd_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_stream_byte,
    output logic             o_res_valid,
    output ltpd_pkg::t_result o_result
);

    logic [ltpd_pkg::COUNT_W-1:0] r_header_count, n_header_count;
    logic                         r_in_payload, n_in_payload;
    logic [31:0]                  r_length_word, n_length_word;
    logic [31:0]                  r_type_word, n_type_word;
    logic [31:0]                  r_bytes_remaining, n_bytes_remaining;
    logic                         r_first_pending, n_first_pending;
    logic                         w_last_byte;
    logic [4:0]                   w_lane;

    assign w_last_byte = (r_bytes_remaining <= 32'd1);
    assign w_lane      = {r_header_count[1:0], 3'b000};

    always_comb begin
        n_header_count    = r_header_count;
        n_in_payload      = r_in_payload;
        n_length_word     = r_length_word;
        n_type_word       = r_type_word;
        n_bytes_remaining = r_bytes_remaining;
        n_first_pending   = r_first_pending;
        o_res_valid       = 1'b0;
        o_result          = '0;
        o_result.message_type   = r_type_word;
        o_result.message_length = r_length_word;

        if (!r_in_payload) begin
            if (r_header_count < ltpd_pkg::COUNT_W'(ltpd_pkg::WORD_BYTES)) begin
                n_length_word[w_lane +: 8] = i_stream_byte;
            end else begin
                n_type_word[w_lane +: 8] = i_stream_byte;
            end
            if (r_header_count != ltpd_pkg::LAST_HEADER_POS) begin
                n_header_count = r_header_count + 1'b1;
            end else begin
                n_header_count = '0;
                if (r_length_word == 32'd0) begin
                    o_res_valid                = 1'b1;
                    o_result.message_type      = n_type_word;
                    o_result.first_of_message  = 1'b1;
                    o_result.last_of_message   = 1'b1;
                    o_result.empty_message     = 1'b1;
                end else begin
                    n_in_payload      = 1'b1;
                    n_bytes_remaining = r_length_word;
                    n_first_pending   = 1'b1;
                end
            end
        end else begin
            o_res_valid               = 1'b1;
            o_result.payload_byte     = i_stream_byte;
            o_result.first_of_message = r_first_pending;
            o_result.last_of_message  = w_last_byte;
            n_first_pending           = 1'b0;
            if (w_last_byte) begin
                n_bytes_remaining = '0;
                n_in_payload      = 1'b0;
                n_header_count    = '0;
            end else begin
                n_bytes_remaining = r_bytes_remaining - 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_count    <= '0;
            r_in_payload      <= 1'b0;
            r_length_word     <= '0;
            r_type_word       <= '0;
            r_bytes_remaining <= '0;
            r_first_pending   <= 1'b0;
        end else if (i_accept) begin
            r_header_count    <= n_header_count;
            r_in_payload      <= n_in_payload;
            r_length_word     <= n_length_word;
            r_type_word       <= n_type_word;
            r_bytes_remaining <= n_bytes_remaining;
            r_first_pending   <= n_first_pending;
        end
    end

    a_empty_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_result.empty_message) |->
        (o_result.first_of_message && o_result.last_of_message
         && o_result.payload_byte == 8'd0 && o_result.message_length == 32'd0))
        else $error("empty item without first/last marks");

    a_payload_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_payload |-> (r_header_count == '0 && r_bytes_remaining != 32'd0))
        else $error("payload state inconsistent");

    a_last_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_in_payload && w_last_byte) |=> !r_in_payload)
        else $error("payload did not end after last byte");

endmodule

### rtl/ltpd_out_reg.sv
`timescale 1ns / 1ps

module ltpd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  ltpd_pkg::t_result i_result,
    input  logic              i_ready,
    output logic              o_can_load,
    output logic              o_valid,
    output ltpd_pkg::t_result o_result
);

    logic              r_valid;
    ltpd_pkg::t_result r_result;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

### rtl/length_type_prefixed_deframer.sv
`timescale 1ns / 1ps
// channel | handshake          | payload
// in      | i_valid / o_ready  | i_stream_byte[7:0]
// out     | o_valid / i_ready  | o_payload_byte, o_message_type, o_message_length,
//         |                    | o_first_of_message, o_last_of_message, o_empty_message
//
// One item per cycle while o_ready is high; results come the cycle after input.
// Header bytes give no result; the eighth header byte gives one only when the
// length is zero. Each payload byte gives one result.
// Synchronous active-low reset clears the header counter and payload state.
// A stalled output holds; o_ready drops only while a result waits and
// i_ready is low.

module length_type_prefixed_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_stream_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_payload_byte,
    output logic [31:0] o_message_type,
    output logic [31:0] o_message_length,
    output logic        o_first_of_message,
    output logic        o_last_of_message,
    output logic        o_empty_message
);

    logic              w_accept;
    logic              w_res_valid;
    logic              w_can_load;
    ltpd_pkg::t_result w_result;
    ltpd_pkg::t_result w_out;

    assign o_ready  = w_can_load;
    assign w_accept = i_valid && w_can_load;

    ltpd_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_stream_byte (i_stream_byte),
        .o_res_valid   (w_res_valid),
        .o_result      (w_result)
    );

    ltpd_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_accept && w_res_valid),
        .i_result   (w_result),
        .i_ready    (i_ready),
        .o_can_load (w_can_load),
        .o_valid    (o_valid),
        .o_result   (w_out)
    );

    assign o_payload_byte     = w_out.payload_byte;
    assign o_message_type     = w_out.message_type;
    assign o_message_length   = w_out.message_length;
    assign o_first_of_message = w_out.first_of_message;
    assign o_last_of_message  = w_out.last_of_message;
    assign o_empty_message    = w_out.empty_message;

endmodule
